FILE: src/itc_pkg.sv
// itc_pkg: shared types and constants for the decimal text converter.
// Used by itc_digit_cell and int_to_decimal_ascii_padded; no dependencies.
`timescale 1ns / 1ps

package itc_pkg;

    // Width of the signed input number
    localparam int VALUE_BITS = 32;
    // Decimal digits needed for the unsigned magnitude (log10(2) ~ 0.30103)
    localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int NDIG_W = $clog2(DIGITS + 1);
    // Character position / field length counters (fields up to 127 characters)
    localparam int POS_W  = 7;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [5:0]                   min_width;
    } t_in_word;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_out_word;

    // Control shared by every digit cell in the chain
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 correction then shift in one bit from below
        logic shift;   // take the whole digit of the lower neighbour
    } t_cell_ctrl;

endpackage

FILE: src/itc_digit_cell.sv
// itc_digit_cell: one BCD digit of the shift-add-3 conversion chain.
// Depends on itc_pkg for the cell control struct.
`timescale 1ns / 1ps

module itc_digit_cell (
    input  logic               i_clk,
    input  itc_pkg::t_cell_ctrl i_ctrl,
    input  logic               i_bit,
    input  logic [3:0]         i_digit,
    output logic               o_bit,
    output logic [3:0]         o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // add 3 when the digit would overflow past 9 after doubling
    assign w_adj = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_bit   = w_adj[3];
    assign o_digit = r_digit;

    // next digit
    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctrl.dabble) begin
            n_digit = {w_adj[2:0], i_bit};
        end else if (i_ctrl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

FILE: src/int_to_decimal_ascii_padded.sv
// int_to_decimal_ascii_padded: top level, signed binary to padded decimal text.
// Depends on itc_pkg and itc_digit_cell.
`timescale 1ns / 1ps

// Converts one signed number at a time into right-justified decimal ASCII,
// one character per output word: leading spaces up to the field width
// (capped at MAX_WIDTH), a '-' for negative values, then the digits most
// significant first; is_last flags the final character. The digit cell chain
// shifts in one magnitude bit per cycle, then shifts out one digit per cycle
// while leading zeros are skipped and, when the output is not stalled, while
// digits are sent. The input is taken only when the converter is idle; the
// last character of one item may still wait at the output while the next
// item is taken.

module int_to_decimal_ascii_padded #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  itc_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output itc_pkg::t_out_word  o_out_word
);

    localparam int VB = itc_pkg::VALUE_BITS;
    localparam int ND = itc_pkg::DIGITS;
    localparam int PW = itc_pkg::POS_W;
    localparam logic [PW-1:0] MaxW = PW'(MAX_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CONV  = 4'b0010,
        S_ALIGN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state                        r_state;
    logic [VB-1:0]                 r_mag;
    logic                          r_neg;
    logic [PW-1:0]                 r_width;
    logic [itc_pkg::CNT_W-1:0]     r_cnt;
    logic [itc_pkg::NDIG_W-1:0]    r_ndig;
    logic [PW-1:0]                 r_total;
    logic [PW-1:0]                 r_pad;
    logic [PW-1:0]                 r_pos;
    logic                          r_out_valid;
    itc_pkg::t_out_word            r_out_word;

    itc_pkg::t_cell_ctrl           w_ctrl;
    logic [ND-1:0]                 w_carry;
    logic [3:0]                    w_digit [ND];
    logic [3:0]                    w_top;
    logic                          w_accept;
    logic                          w_slot_free;
    logic                          w_align_skip;
    logic                          w_is_pad;
    logic                          w_is_sign;
    logic                          w_is_last;
    logic [7:0]                    w_char;
    logic [VB-1:0]                 w_raw;
    logic [VB-1:0]                 w_mag;
    logic [PW-1:0]                 w_in_width;
    logic [PW-1:0]                 w_body;
    logic [PW-1:0]                 w_total;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // input decode: magnitude and saturated width
    assign w_raw      = i_in_word.value;
    assign w_mag      = w_raw[VB-1] ? (~w_raw + 1'b1) : w_raw;
    assign w_in_width = ({1'b0, i_in_word.min_width} > MaxW) ? MaxW
                                                               : {1'b0, i_in_word.min_width};

    // field length once the digit count is known
    assign w_body  = PW'(r_ndig) + PW'(r_neg);
    assign w_total = (r_width > w_body) ? r_width : w_body;

    // character selection
    assign w_top        = w_digit[ND-1];
    assign w_align_skip = (w_top == 4'd0) && (r_ndig > itc_pkg::NDIG_W'(1));
    assign w_is_pad     = (r_pos < r_pad);
    assign w_is_sign    = r_neg && (r_pos == r_pad);
    assign w_is_last    = (r_pos == r_total - 1'b1);
    assign w_char       = w_is_pad  ? itc_pkg::CHAR_SPACE :
                          w_is_sign ? itc_pkg::CHAR_MINUS :
                                      itc_pkg::CHAR_ZERO + {4'd0, w_top};

    // chain control
    always_comb begin
        w_ctrl.clear  = w_accept;
        w_ctrl.dabble = (r_state == S_CONV);
        w_ctrl.shift  = ((r_state == S_ALIGN) && w_align_skip) ||
                        ((r_state == S_EMIT) && w_slot_free && !w_is_pad && !w_is_sign);
    end

    // digit cell chain, least significant digit at index 0
    for (genvar k = 0; k < ND; k++) begin : g_cell
        if (k == 0) begin : g_first
            itc_digit_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_bit   (r_mag[VB-1]),
                .i_digit (4'd0),
                .o_bit   (w_carry[k]),
                .o_digit (w_digit[k])
            );
        end else begin : g_next
            itc_digit_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_bit   (w_carry[k-1]),
                .i_digit (w_digit[k-1]),
                .o_bit   (w_carry[k]),
                .o_digit (w_digit[k])
            );
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // while emitting, the output slot is refilled below
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mag   <= w_mag;
                        r_neg   <= w_raw[VB-1];
                        r_width <= w_in_width;
                        r_cnt   <= itc_pkg::CNT_W'(VB);
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_mag <= {r_mag[VB-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == itc_pkg::CNT_W'(1)) begin
                        r_ndig  <= itc_pkg::NDIG_W'(ND);
                        r_state <= S_ALIGN;
                    end
                end
                S_ALIGN: begin
                    // drop leading zero digits, keeping at least one
                    if (w_align_skip) begin
                        r_ndig <= r_ndig - 1'b1;
                    end else begin
                        r_total <= w_total;
                        r_pad   <= w_total - w_body;
                        r_pos   <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_valid          <= 1'b1;
                        r_out_word.char_code <= w_char;
                        r_out_word.is_last   <= w_is_last;
                        r_pos                <= r_pos + 1'b1;
                        if (w_is_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // the top digit never overflows during conversion
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> !w_carry[ND-1])
        else $error("digit chain overflow");

    // an accepted word starts conversion
    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CONV))
        else $error("accepted word did not start conversion");

    // the last character returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && w_slot_free && w_is_last) |=> (r_state == S_IDLE))
        else $error("last character did not end the item");

    // only spaces, minus signs and digits leave the block
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_word.char_code == itc_pkg::CHAR_SPACE) ||
                         (r_out_word.char_code == itc_pkg::CHAR_MINUS) ||
                         ((r_out_word.char_code >= itc_pkg::CHAR_ZERO) &&
                          (r_out_word.char_code <= 8'h39))))
        else $error("illegal output character");

endmodule

FILE: sim/tb_int_to_decimal_ascii_padded.sv
// tb_int_to_decimal_ascii_padded: self-checking bench for the padded decimal text converter.
// Depends on itc_pkg and int_to_decimal_ascii_padded; directed table first, then random numbers,
// each output word checked against the expected text or a behavioural prediction of the character stream.
`timescale 1ns / 1ps

module tb_int_to_decimal_ascii_padded;

    localparam int MAX_WIDTH    = 32;
    localparam int DIR_ROWS     = 23;
    localparam int RAND_ITEMS   = 290;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int REPORT_MAX   = 10;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    itc_pkg::t_in_word    i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    itc_pkg::t_out_word   o_out_word;

    // Characters still owed by the block, oldest first
    itc_pkg::t_out_word  pending_chars [$];
    int         mismatches = 0;
    int         cycles     = 0;
    int         ready_hold = 0;
    bit         steady     = 1'b0;

    int_to_decimal_ascii_padded #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #6 i_clk = ~i_clk;

    // Directed table: an empty text means the prediction is used
    logic signed [itc_pkg::VALUE_BITS-1:0] dir_value [DIR_ROWS] = '{
        32'sd0, 32'sd0, 32'sd5, -32'sd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
        32'h8000_0000, -32'sd1, 32'sd12345, 32'sd9, 32'sd10, 32'sd1000000000,
        -32'sd1000000000, 32'sd999999999, 32'sd0, -32'sd1, 32'h7FFF_FFFF,
        32'h8000_0000, 32'sd42, 32'h8000_0001, 32'sd1, 32'sd100
    };
    logic [5:0] dir_width [DIR_ROWS] = '{
        6'd0, 6'd1, 6'd3, 6'd3, 6'd0, 6'd0, 6'd11, 6'd12, 6'd1, 6'd2, 6'd1, 6'd2,
        6'd0, 6'd0, 6'd0, 6'd32, 6'd32, 6'd33, 6'd63, 6'd40, 6'd10, 6'd31, 6'd4
    };
    string dir_text [DIR_ROWS] = '{
        "0", "0", "  5", " -7", "2147483647", "-2147483648", "-2147483648",
        " -2147483648", "-1", "12345", "9", "10", "1000000000", "-1000000000",
        "999999999", "", "", "", "", "", "-2147483647", "", " 100"
    };

    // Gap length: mostly none, some short, a few long; none at all while steady
    function automatic int pick_gap(input int idle_pct);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r >= idle_pct)
            return 0;
        if (r >= idle_pct / 6)
            return $urandom_range(1, 3);
        return $urandom_range(10, 24);
    endfunction

    // Expected character stream for one number: padding, sign, digits msd first
    function automatic void predict_text(input logic signed [itc_pkg::VALUE_BITS-1:0] value,
                                         input logic [5:0] width);
        logic [itc_pkg::VALUE_BITS-1:0] mag;
        logic [7:0]                     digs [$];
        bit                             neg;
        int                             field, body, total, k;
        neg   = value[itc_pkg::VALUE_BITS-1];
        mag   = neg ? (~value + 1'b1) : value;
        field = (int'(width) > MAX_WIDTH) ? MAX_WIDTH : int'(width);
        do begin
            digs.push_front(itc_pkg::CHAR_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        body  = digs.size() + (neg ? 1 : 0);
        total = (field > body) ? field : body;
        for (k = 0; k < total - body; k++)
            pending_chars.push_back('{char_code: itc_pkg::CHAR_SPACE, is_last: 1'b0});
        if (neg)
            pending_chars.push_back('{char_code: itc_pkg::CHAR_MINUS, is_last: 1'b0});
        foreach (digs[i])
            pending_chars.push_back('{char_code: digs[i], is_last: (i == digs.size() - 1)});
    endfunction

    // Random number: full range, small, decade edges, extremes, shifted magnitudes
    function automatic logic signed [itc_pkg::VALUE_BITS-1:0] random_number();
        logic signed [itc_pkg::VALUE_BITS-1:0] v;
        int                                    p;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 99);
            3: begin
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p - $urandom_range(0, 1);
            end
            4: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h8000_0001;
                    default: v = '0;
                endcase
            end
            default: v = $signed($urandom) >>> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 1) && v != 32'h8000_0000)
            v = -v;
        return v;
    endfunction

    function automatic logic [5:0] random_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 6'($urandom_range(0, 12));
        if (r < 85)
            return 6'($urandom_range(13, 32));
        return 6'($urandom_range(33, 63));
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Offer one number and hold it until taken; expectations queued on acceptance
    task automatic send_number(input logic signed [itc_pkg::VALUE_BITS-1:0] value,
                               input logic [5:0] width, input string text);
        int gap;
        int i;
        gap = pick_gap(45);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in_word.value     <= value;
        i_in_word.min_width <= width;
        do @(posedge i_clk); while (!o_in_ready);
        if (text.len() == 0)
            predict_text(value, width);
        else
            for (i = 0; i < text.len(); i++)
                pending_chars.push_back('{char_code: text[i], is_last: (i == text.len() - 1)});
    endtask

    // Output back-pressure
    always @(posedge i_clk) begin : out_stall
        int gap;
        if (ready_hold > 0) begin
            ready_hold  <= ready_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            gap = pick_gap(30);
            i_out_ready <= (gap == 0);
            ready_hold  <= (gap > 0) ? gap - 1 : 0;
        end
    end

    // Compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin : out_check
        itc_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chars.size() == 0) begin
                note_mismatch($sformatf("unexpected word char=%h last=%b",
                                        o_out_word.char_code, o_out_word.is_last));
            end else begin
                want = pending_chars.pop_front();
                if (o_out_word.char_code !== want.char_code
                        || o_out_word.is_last !== want.is_last)
                    note_mismatch($sformatf(
                        "word mismatch: exp char=%h last=%b, got char=%h last=%b",
                        want.char_code, want.is_last,
                        o_out_word.char_code, o_out_word.is_last));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_int_to_decimal_ascii_padded: errors");
            $finish;
        end
    end

    initial begin : stimulus
        int idx;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (idx = 0; idx < DIR_ROWS; idx++)
            send_number(dir_value[idx], dir_width[idx], dir_text[idx]);

        for (idx = 0; idx < RAND_ITEMS; idx++) begin
            // sender holds off until the output side has fully drained
            if (idx == 140) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_chars.size() != 0);
            end
            steady = (idx >= 200 && idx < 240);
            send_number(random_number(), random_width(), "");
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_chars.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_int_to_decimal_ascii_padded: clean");
        else
            $display("tb_int_to_decimal_ascii_padded: errors");
        $finish;
    end

endmodule

FILE: filelist.f
src/itc_pkg.sv
src/itc_digit_cell.sv
src/int_to_decimal_ascii_padded.sv
sim/tb_int_to_decimal_ascii_padded.sv
